// ===== rtl/circular_list_cursor_engine_assert.svh =====
// assertion macros for the circular list cursor engine
// used by the top level only, clocked on clk with active low rst_n
`ifndef CIRCULAR_LIST_CURSOR_ENGINE_ASSERT_SVH
`define CIRCULAR_LIST_CURSOR_ENGINE_ASSERT_SVH

// same-cycle implication
`define CLCE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CLCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/clce_pkg.sv =====
// shared types and constants for the circular list cursor engine
// no dependencies
package clce_pkg;

    localparam int NODES = 4096;
    localparam int IDX_W = $clog2(NODES);
    localparam int CNT_W = IDX_W + 1;
    localparam int AMT_W = 32;
    localparam int OP_W  = 3;
    localparam int DIV_CNT_W = $clog2(AMT_W);

    typedef enum logic [OP_W-1:0] {
        OP_ERASE  = 3'd0,
        OP_INSERT = 3'd1,
        OP_MOVE0  = 3'd2,
        OP_MOVE1  = 3'd3,
        OP_QUERY  = 3'd4,
        OP_INIT   = 3'd5
    } op_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_ER_WR,
        DP_INS_OVF,
        DP_INS_SELF,
        DP_INS_W1,
        DP_INS_W2,
        DP_DIV_START,
        DP_FOLD,
        DP_WALK,
        DP_INIT_OVF,
        DP_INIT_EMPTY,
        DP_INIT_SETUP,
        DP_INIT_WR,
        DP_LOAD_OUT
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ER_WR,
        S_IN_W1,
        S_IN_W2,
        S_IN_SELF,
        S_DIV_WAIT,
        S_FOLD,
        S_WALK,
        S_INIT_WR,
        S_RESP
    } state_t;

    typedef struct packed {
        dp_op_t op;
        logic   rd_link;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic live_zero;
        logic last_full;
        logic init_big;
        logic init_nonpos;
        logic div_done;
        logic rem_zero;
        logic walk_last;
        logic init_last;
    } sts_t;

endpackage

// ===== rtl/clce_div.sv =====
// remainder unit: restoring division, one dividend bit per cycle
// depends on clce_pkg
module clce_div
    import clce_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [AMT_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [CNT_W-1:0] rem
);

    logic [AMT_W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W:0]       trial;

    assign trial = {rem_reg, quo_reg[AMT_W-1]};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = DIV_CNT_W'(AMT_W - 1);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            quo_next = quo_reg << 1;
            if (trial >= {1'b0, divisor})
                rem_next = CNT_W'(trial - {1'b0, divisor});
            else
                rem_next = trial[CNT_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/clce_dp.sv =====
// datapath: link memories, list registers, remainder unit, result register
// depends on clce_pkg and clce_div
module clce_dp
    import clce_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output sts_t             sts,
    input  logic [OP_W-1:0]  operation,
    input  logic [AMT_W-1:0] amount,
    output logic             cursor_valid,
    output logic [IDX_W-1:0] cursor_index,
    output logic             overflow
);

    logic [IDX_W-1:0] side0_mem [NODES];
    logic [IDX_W-1:0] side1_mem [NODES];
    logic [IDX_W-1:0] s0_q, s1_q;

    op_t              op_reg;
    logic [AMT_W-1:0] amt_reg;
    logic [IDX_W-1:0] cursor_reg, cursor_next;
    logic [CNT_W-1:0] live_reg, live_next;
    logic [IDX_W-1:0] last_reg, last_next;
    logic [IDX_W-1:0] prev_reg, prev_next;
    logic [IDX_W-1:0] step_reg, step_next;
    logic [IDX_W-1:0] init_i_reg, init_i_next;
    logic             dir_reg, dir_next;
    logic             ovf_reg, ovf_next;
    logic             cv_reg;
    logic [IDX_W-1:0] ci_reg;
    logic             ov_reg;

    logic             neg;
    logic [AMT_W-1:0] mag;
    logic [IDX_W-1:0] fresh, link, rd_addr;
    logic [CNT_W-1:0] rem, half;
    logic             div_done;

    logic             s0_we, s1_we;
    logic [IDX_W-1:0] s0_wa, s0_wd, s1_wa, s1_wd;

    assign neg     = amt_reg[AMT_W-1];
    assign mag     = neg ? AMT_W'(~amt_reg + 1'b1) : amt_reg;
    assign fresh   = IDX_W'(last_reg + 1'b1);
    assign link    = dir_reg ? s1_q : s0_q;
    assign rd_addr = cmd.rd_link ? link : cursor_reg;
    assign half    = live_reg >> 1;

    clce_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == DP_DIV_START),
        .dividend (mag),
        .divisor  (live_reg),
        .done     (div_done),
        .rem      (rem)
    );

    // memory write ports, one per link array
    always_comb
    begin
        s0_we = 1'b0;
        s1_we = 1'b0;
        s0_wa = cursor_reg;
        s0_wd = fresh;
        s1_wa = cursor_reg;
        s1_wd = fresh;
        unique case (cmd.op)
            DP_ER_WR:
            begin
                s1_we = 1'b1;
                s1_wa = s0_q;
                s1_wd = s1_q;
                s0_we = 1'b1;
                s0_wa = s1_q;
                s0_wd = s0_q;
            end
            DP_INS_SELF:
            begin
                s0_we = 1'b1;
                s0_wa = fresh;
                s1_we = 1'b1;
                s1_wa = fresh;
            end
            DP_INS_W1:
            begin
                s1_we = 1'b1;
                s1_wa = fresh;
                s1_wd = cursor_reg;
                s0_we = 1'b1;
                s0_wa = fresh;
                s0_wd = s0_q;
            end
            DP_INS_W2:
            begin
                s1_we = 1'b1;
                s1_wa = prev_reg;
                s0_we = 1'b1;
            end
            DP_INIT_WR:
            begin
                s0_we = 1'b1;
                s0_wa = init_i_reg;
                s0_wd = (init_i_reg == last_reg) ? IDX_W'(1) : IDX_W'(init_i_reg + 1'b1);
                s1_we = 1'b1;
                s1_wa = init_i_reg;
                s1_wd = (init_i_reg == IDX_W'(1)) ? last_reg : IDX_W'(init_i_reg - 1'b1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s0_we)
            side0_mem[s0_wa] <= s0_wd;
        s0_q <= side0_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (s1_we)
            side1_mem[s1_wa] <= s1_wd;
        s1_q <= side1_mem[rd_addr];
    end

    // list register updates
    always_comb
    begin
        cursor_next = cursor_reg;
        live_next   = live_reg;
        last_next   = last_reg;
        prev_next   = prev_reg;
        step_next   = step_reg;
        init_i_next = init_i_reg;
        dir_next    = dir_reg;
        ovf_next    = ovf_reg;
        unique case (cmd.op) inside
            DP_CAPTURE:
                ovf_next = 1'b0;
            DP_ER_WR:
            begin
                cursor_next = s0_q;
                live_next   = live_reg - 1'b1;
            end
            DP_INS_OVF, DP_INIT_OVF:
                ovf_next = 1'b1;
            DP_INS_SELF:
            begin
                cursor_next = fresh;
                last_next   = fresh;
                live_next   = live_reg + 1'b1;
            end
            DP_INS_W1:
                prev_next = s0_q;
            DP_INS_W2:
            begin
                last_next = fresh;
                live_next = live_reg + 1'b1;
            end
            DP_DIV_START:
                dir_next = (op_reg == OP_MOVE1) ^ neg;
            DP_FOLD:
            begin
                if (rem > half)
                begin
                    step_next = IDX_W'(live_reg - rem);
                    dir_next  = ~dir_reg;
                end
                else
                    step_next = rem[IDX_W-1:0];
            end
            DP_WALK:
            begin
                cursor_next = link;
                step_next   = step_reg - 1'b1;
            end
            DP_INIT_EMPTY:
            begin
                live_next   = '0;
                last_next   = '0;
                cursor_next = IDX_W'(1);
            end
            DP_INIT_SETUP:
            begin
                live_next   = {1'b0, amt_reg[IDX_W-1:0]};
                last_next   = amt_reg[IDX_W-1:0];
                cursor_next = IDX_W'(1);
                init_i_next = IDX_W'(1);
            end
            DP_INIT_WR:
                init_i_next = IDX_W'(init_i_reg + 1'b1);
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            live_reg   <= '0;
            last_reg   <= '0;
            prev_reg   <= '0;
            step_reg   <= '0;
            init_i_reg <= '0;
            dir_reg    <= 1'b0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            live_reg   <= live_next;
            last_reg   <= last_next;
            prev_reg   <= prev_next;
            step_reg   <= step_next;
            init_i_reg <= init_i_next;
            dir_reg    <= dir_next;
            ovf_reg    <= ovf_next;
        end
    end

    // command beat and result beat payload
    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_CAPTURE)
        begin
            op_reg  <= op_t'(operation);
            amt_reg <= amount;
        end
        if (cmd.op == DP_LOAD_OUT)
        begin
            cv_reg <= (live_reg != '0);
            ci_reg <= (live_reg != '0) ? cursor_reg : '0;
            ov_reg <= ovf_reg;
        end
    end

    assign cursor_valid = cv_reg;
    assign cursor_index = ci_reg;
    assign overflow     = ov_reg;

    always_comb
    begin
        sts.op          = op_reg;
        sts.live_zero   = (live_reg == '0);
        sts.last_full   = (last_reg == IDX_W'(NODES - 1));
        sts.init_big    = !neg && (amt_reg[AMT_W-2:IDX_W] != '0);
        sts.init_nonpos = neg || (amt_reg == '0);
        sts.div_done    = div_done;
        sts.rem_zero    = (rem == '0);
        sts.walk_last   = (step_reg == IDX_W'(1));
        sts.init_last   = (init_i_reg == last_reg);
    end

endmodule

// ===== rtl/clce_ctrl.sv =====
// controller state machine: sequences one command beat through the datapath
// depends on clce_pkg
module clce_ctrl
    import clce_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg) inside
            S_IDLE:
                if (in_valid)
                    state_next = S_DECODE;
            S_DECODE:
            begin
                unique case (sts.op) inside
                    OP_ERASE:
                        state_next = sts.live_zero ? S_RESP : S_ER_WR;
                    OP_INSERT:
                        if (sts.last_full)
                            state_next = S_RESP;
                        else if (sts.live_zero)
                            state_next = S_IN_SELF;
                        else
                            state_next = S_IN_W1;
                    OP_MOVE0, OP_MOVE1:
                        state_next = sts.live_zero ? S_RESP : S_DIV_WAIT;
                    OP_INIT:
                        if (sts.init_big || sts.init_nonpos)
                            state_next = S_RESP;
                        else
                            state_next = S_INIT_WR;
                    default:
                        state_next = S_RESP;
                endcase
            end
            S_ER_WR, S_IN_W2, S_IN_SELF:
                state_next = S_RESP;
            S_IN_W1:
                state_next = S_IN_W2;
            S_DIV_WAIT:
                if (sts.div_done)
                    state_next = S_FOLD;
            S_FOLD:
                state_next = sts.rem_zero ? S_RESP : S_WALK;
            S_WALK:
                if (sts.walk_last)
                    state_next = S_RESP;
            S_INIT_WR:
                if (sts.init_last)
                    state_next = S_RESP;
            S_RESP:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op      = DP_NOP;
        cmd.rd_link = 1'b0;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    cmd.op = DP_CAPTURE;
            S_DECODE:
            begin
                unique case (sts.op) inside
                    OP_INSERT:
                        if (sts.last_full)
                            cmd.op = DP_INS_OVF;
                    OP_MOVE0, OP_MOVE1:
                        if (!sts.live_zero)
                            cmd.op = DP_DIV_START;
                    OP_INIT:
                        if (sts.init_big)
                            cmd.op = DP_INIT_OVF;
                        else if (sts.init_nonpos)
                            cmd.op = DP_INIT_EMPTY;
                        else
                            cmd.op = DP_INIT_SETUP;
                    default:
                        cmd.op = DP_NOP;
                endcase
            end
            S_ER_WR:    cmd.op = DP_ER_WR;
            S_IN_W1:    cmd.op = DP_INS_W1;
            S_IN_W2:    cmd.op = DP_INS_W2;
            S_IN_SELF:  cmd.op = DP_INS_SELF;
            S_FOLD:     cmd.op = DP_FOLD;
            S_WALK:
            begin
                cmd.op      = DP_WALK;
                cmd.rd_link = 1'b1;
            end
            S_INIT_WR:  cmd.op = DP_INIT_WR;
            S_RESP:
                if (out_free)
                    cmd.op = DP_LOAD_OUT;
            default:
                cmd.op = DP_NOP;
        endcase
    end

    always_comb
    begin
        if (state_reg == S_RESP && out_free)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/circular_list_cursor_engine.sv =====
// top level of the circular list cursor engine
// depends on clce_pkg, clce_ctrl, clce_dp and circular_list_cursor_engine_assert.svh
//
// Array-backed circular doubly linked list with a cursor, up to 4095 nodes
// numbered from 1. One command beat in gives one result beat out. Commands
// run one at a time; in_stall stays high from acceptance until the result is
// placed in the output register, and the next command can be taken while
// that result still waits on out_stall. A move waits on the bit-serial
// remainder unit and then walks k links, where k is at most half the live
// count, one link memory read per cycle. Link memories are not cleared after
// reset and need no clearing pass; entries are written before they are ever
// read.
`include "circular_list_cursor_engine_assert.svh"

module circular_list_cursor_engine
    import clce_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [OP_W-1:0]  operation,
    input  logic [AMT_W-1:0] amount,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             cursor_valid,
    output logic [IDX_W-1:0] cursor_index,
    output logic             overflow
);

    // command and status between the sequencer and the datapath
    cmd_t cmd;
    sts_t sts;

    clce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    clce_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .operation    (operation),
        .amount       (amount),
        .cursor_valid (cursor_valid),
        .cursor_index (cursor_index),
        .overflow     (overflow)
    );

    // one command in flight: an accepted beat closes the input side
    `CLCE_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall,
                      "second beat taken while busy")

    // an empty list reports no cursor
    `CLCE_ASSERT_NOW(a_empty_cursor, out_valid && !cursor_valid, cursor_index == '0,
                     "cursor shown for empty list")

    // the link walk only runs on a non-empty list
    `CLCE_ASSERT_NOW(a_walk_nonempty, cmd.op == DP_WALK, !sts.live_zero, "walk on empty list")

endmodule

// ===== bench/circular_list_cursor_engine_tb.sv =====
// self-checking testbench for circular_list_cursor_engine: commands in, cursor beats out
// depends on clce_pkg and the rtl top level; the ring is modeled here to predict results
module circular_list_cursor_engine_tb;
    import clce_pkg::*;

    // spare opcodes that the block treats as a query
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
    localparam int MAX_NODE   = NODES - 1;
    localparam int QUIET_MAX  = 30000;   // cycles with no beat before giving up
    localparam int HOLD_LEN   = 400;     // long receiver hold-off

    typedef struct {
        bit             cv;
        bit [IDX_W-1:0] ci;
        bit             ov;
    } cursor_beat_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [OP_W-1:0]  operation = '0;
    logic [AMT_W-1:0] amount = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic             cursor_valid;
    logic [IDX_W-1:0] cursor_index;
    logic             overflow;

    // ring model: links, live size, cursor and last node number handed out
    bit [IDX_W-1:0] ring_s0 [NODES];
    bit [IDX_W-1:0] ring_s1 [NODES];
    int unsigned    ring_live;
    bit [IDX_W-1:0] ring_cur;
    int unsigned    ring_last;

    cursor_beat_t   pending_beats[$];
    int             errors;
    int             beats_checked;
    int             quiet_cycles;
    bit             tx_idle = 1'b1;
    bit             rx_idle = 1'b1;
    bit             rx_hold = 1'b0;
    int             moves_sent, inits_sent, ovf_seen;

    circular_list_cursor_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .amount       (amount),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cursor_valid (cursor_valid),
        .cursor_index (cursor_index),
        .overflow     (overflow)
    );

    always #2 clk = ~clk;

    // link a fresh node on the side-0 side of the cursor
    function automatic bit grow_ring();
        bit [IDX_W-1:0] fresh;
        bit [IDX_W-1:0] prev;
        if (ring_last >= MAX_NODE)
            return 1'b0;
        ring_last++;
        fresh = ring_last[IDX_W-1:0];
        if (ring_live == 0)
        begin
            ring_s0[fresh] = fresh;
            ring_s1[fresh] = fresh;
            ring_cur = fresh;
        end
        else
        begin
            prev = ring_s0[ring_cur];
            ring_s1[fresh] = ring_cur;
            ring_s0[fresh] = prev;
            ring_s1[prev] = fresh;
            ring_s0[ring_cur] = fresh;
        end
        ring_live++;
        return 1'b1;
    endfunction

    // apply one command to the ring model and return the cursor beat it gives
    function automatic cursor_beat_t apply_command(logic [OP_W-1:0] op, logic [AMT_W-1:0] amt);
        cursor_beat_t   r;
        bit             neg;
        bit             dir;
        bit [31:0]      mag;
        int unsigned    steps;
        int unsigned    n;
        bit [IDX_W-1:0] a;
        bit [IDX_W-1:0] b;
        r.ov = 1'b0;
        neg = amt[AMT_W-1];
        case (op) inside
            OP_ERASE:
            begin
                if (ring_live != 0)
                begin
                    a = ring_s0[ring_cur];
                    b = ring_s1[ring_cur];
                    ring_s1[a] = b;
                    ring_s0[b] = a;
                    ring_cur = a;
                    ring_live--;
                end
            end
            OP_INSERT:
                r.ov = !grow_ring();
            OP_MOVE0, OP_MOVE1:
            begin
                if (ring_live != 0)
                begin
                    dir = (op == OP_MOVE1);
                    mag = neg ? (32'd0 - amt) : amt;
                    if (neg)
                        dir = ~dir;
                    steps = mag % ring_live;
                    if (steps > ring_live / 2)
                    begin
                        steps = ring_live - steps;
                        dir = ~dir;
                    end
                    repeat (steps)
                        ring_cur = dir ? ring_s1[ring_cur] : ring_s0[ring_cur];
                end
            end
            OP_INIT:
            begin
                if (!neg && amt > MAX_NODE)
                    r.ov = 1'b1;
                else
                begin
                    n = neg ? 0 : amt;
                    ring_live = 0;
                    ring_last = 0;
                    repeat (n)
                    begin
                        void'(grow_ring());
                        ring_cur = ring_last[IDX_W-1:0];
                    end
                    ring_cur = 1;
                end
            end
            default: ;
        endcase
        r.cv = (ring_live != 0);
        r.ci = r.cv ? ring_cur : '0;
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // offer one command beat, wait for it to be taken, then predict its result
    task automatic send_command(logic [OP_W-1:0] op, logic [AMT_W-1:0] amt);
        if (tx_idle)
            while ($urandom_range(99) < 23)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid  <= 1'b1;
        operation <= op;
        amount    <= amt;
        do
            @(posedge clk);
        while (in_stall);
        pending_beats.push_back(apply_command(op, amt));
        if (op == OP_MOVE0 || op == OP_MOVE1)
            moves_sent++;
        if (op == OP_INIT)
            inits_sent++;
    endtask

    // receiver side: random stalls plus the long hold-off when asked
    always @(posedge clk)
        out_stall <= rx_hold || (rx_idle && $urandom_range(99) < 23);

    // result checker: every taken beat against the oldest prediction
    always @(posedge clk)
    begin
        cursor_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_beats.size() == 0)
                report("result beat with nothing expected", 1, 0);
            else
            begin
                want = pending_beats.pop_front();
                if (cursor_valid !== want.cv)
                    report("cursor_valid", cursor_valid, want.cv);
                if (cursor_index !== want.ci)
                    report("cursor_index", cursor_index, want.ci);
                if (overflow !== want.ov)
                    report("overflow", overflow, want.ov);
                if (want.ov)
                    ovf_seen++;
                beats_checked++;
            end
        end
    end

    // watchdog on cycles where neither side moves a beat
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > QUIET_MAX)
        begin
            $display("timeout: no beat for %0d cycles", QUIET_MAX);
            $display("circular_list_cursor_engine: mismatch");
            $finish;
        end
    end

    // random command mix: mostly small rings, many moves, a few big ones
    task automatic random_command();
        int             pick;
        logic [OP_W-1:0] op;
        logic [AMT_W-1:0] amt;
        pick = $urandom_range(99);
        amt = $urandom;
        if (pick < 12)
            op = OP_ERASE;
        else if (pick < 34)
            op = OP_INSERT;
        else if (pick < 72)
        begin
            op = $urandom_range(1) ? OP_MOVE1 : OP_MOVE0;
            if ($urandom_range(1))
                amt = $urandom_range(40) - 20;
        end
        else if (pick < 78)
            op = OP_QUERY;
        else if (pick < 80)
            op = $urandom_range(1) ? OP_SPARE7 : OP_SPARE6;
        else
        begin
            op = OP_INIT;
            pick = $urandom_range(99);
            if (pick < 80)
                amt = $urandom_range(12);
            else if (pick < 88)
                amt = -$urandom_range(100);
            else if (pick < 95)
                amt = MAX_NODE + $urandom_range(1000);
            else if (pick < 97)
                amt = MAX_NODE;
            else
                amt = $urandom_range(300);
        end
        send_command(op, amt);
    endtask

    task automatic test_directed();
        send_command(OP_QUERY, 0);
        send_command(OP_ERASE, 0);           // erase on empty list
        send_command(OP_MOVE0, 5);           // move on empty list
        send_command(OP_INSERT, 0);          // first node becomes cursor
        send_command(OP_INSERT, 0);
        send_command(OP_ERASE, 0);
        send_command(OP_ERASE, 0);           // last node gone, cursor kept but invalid
        send_command(OP_INSERT, 0);
        send_command(OP_INIT, 0);
        send_command(OP_INIT, -5);           // non-positive init empties the list
        send_command(OP_INIT, NODES);        // too big, refused
        send_command(OP_INIT, 32'h7fff_ffff);
        send_command(OP_INIT, MAX_NODE);     // full ring
        send_command(OP_INSERT, 0);          // numbers exhausted
        send_command(OP_MOVE1, 32'h8000_0000);
        send_command(OP_MOVE0, 32'h7fff_ffff);
        send_command(OP_INIT, 5);
        send_command(OP_MOVE0, 3);           // longer than half, walks back
        send_command(OP_MOVE1, 2);
        send_command(OP_MOVE1, -1);          // negative count flips direction
        send_command(OP_MOVE0, 32'hffff_ffff);
        send_command(OP_SPARE6, 32'hffff_ffff);
        send_command(OP_SPARE7, 0);
        send_command(OP_ERASE, 0);
        send_command(OP_QUERY, 32'h5555_aaaa);
    endtask

    task automatic test_random(int count);
        repeat (count)
            random_command();
    endtask

    // no idling on either side for a stretch
    task automatic test_back_to_back();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_command(OP_INIT, 9);
        test_random(60);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // receiver holds off while commands keep coming, so the input stalls
    task automatic test_output_hold();
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_LEN)
                    @(posedge clk);
                rx_hold <= 1'b0;
            end
            begin
                send_command(OP_INIT, 6);
                test_random(20);
            end
        join
    endtask

    initial
    begin
        int waited;
        errors = 0;
        beats_checked = 0;
        quiet_cycles = 0;
        moves_sent = 0;
        inits_sent = 0;
        ovf_seen = 0;
        ring_live = 0;
        ring_cur = '0;
        ring_last = 0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(250);
        test_back_to_back();
        test_output_hold();
        test_random(150);
        in_valid <= 1'b0;

        // drain outstanding results, then a short tail for stray beats
        waited = 0;
        while (pending_beats.size() != 0 && waited < 4 * QUIET_MAX)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (50)
            @(posedge clk);
        if (pending_beats.size() != 0)
            report("results never delivered", 0, pending_beats.size());

        $display("checked %0d result beats: %0d moves, %0d inits, %0d refused growths",
                 beats_checked, moves_sent, inits_sent, ovf_seen);
        if (errors == 0)
            $display("circular_list_cursor_engine: match");
        else
            $display("circular_list_cursor_engine: mismatch");
        $finish;
    end

endmodule
